[sv/fpds_pkg.sv]
// fpds_pkg: shared types, constants and codes for the five-point derivative stencil core
// used by every module of the block; depends on nothing

package fpds_pkg;

   // sequence length and counters
   localparam int MAX_LENGTH = 65536;
   localparam int CNT_W      = $clog2(MAX_LENGTH);
   localparam int NODE_W     = 16;

   // sample and result widths
   localparam int SAMPLE_W = 24;
   localparam int WIN_LEN  = 6;
   localparam int SUM_W    = 34;
   localparam int MAG_W    = SUM_W - 1;
   localparam int SCALE_W  = 32;
   localparam int DERIV_W  = 48;

   // split of the magnitude for the two partial products
   localparam int LO_W    = 17;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int P0_W    = LO_W + SCALE_W;
   localparam int P1_W    = HI_W + SCALE_W;
   localparam int FULL_W  = MAG_W + SCALE_W + 1;
   localparam int FRAC_W  = 16;
   localparam int QFULL_W = FULL_W - FRAC_W;

   // rounding offsets, half up on the signed value
   localparam logic [FULL_W-1:0] ROUND_POS = FULL_W'(32768);
   localparam logic [FULL_W-1:0] ROUND_NEG = FULL_W'(32767);

   // saturation limits on the magnitude
   localparam logic [DERIV_W-1:0] LIMIT_POS = {1'b0, {(DERIV_W-1){1'b1}}};
   localparam logic [DERIV_W-1:0] LIMIT_NEG = {1'b1, {(DERIV_W-1){1'b0}}};

   // queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'b1;

   // mode codes
   localparam logic [1:0] MODE_FIRST   = 2'd0;
   localparam logic [1:0] MODE_SECOND5 = 2'd1;
   localparam logic [1:0] MODE_SECOND6 = 2'd2;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

   // one queued sample with the window it completes
   typedef struct packed {
      logic [WIN_LEN-1:0][SAMPLE_W-1:0] win;
      logic [CNT_W-1:0]                 count;
      logic                             first;
      logic                             last;
      logic                             short_seq;
   } entry_type;

   // result tag carried alongside the arithmetic
   typedef struct packed {
      logic [NODE_W-1:0] node_index;
      logic              too_short;
      logic              end_of_run;
   } meta_type;

   // result being produced from the head entry
   typedef enum logic [2:0] {
      JOB_START,
      JOB_SHORT,
      JOB_LEFT_FAR,
      JOB_LEFT_NEAR,
      JOB_INNER_LO,
      JOB_INNER_HI,
      JOB_RIGHT_NEAR,
      JOB_RIGHT_FAR
   } job_type;

endpackage

[sv/fpds_front.sv]
// fpds_front: sample window, sequence counter and classification of each sample
// depends on fpds_pkg

module fpds_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fpds_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_last,
   input  logic                          queue_full,
   output logic                          push,
   output fpds_pkg::entry_type           push_entry
);

   logic [fpds_pkg::WIN_LEN-1:0][fpds_pkg::SAMPLE_W-1:0] window_ff, window_in;
   logic [fpds_pkg::CNT_W-1:0] count_ff, count_in;
   logic accept;
   logic last_eff;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // classify the sample against its place in the sequence
   always_comb begin
      last_eff  = req_last || (count_ff == fpds_pkg::CNT_W'(fpds_pkg::MAX_LENGTH - 1));
      window_in = {req_sample, window_ff[fpds_pkg::WIN_LEN-1:1]};
      count_in  = last_eff ? '0 : count_ff + fpds_pkg::CNT_W'(1);
      push      = accept && (last_eff || (count_ff >= fpds_pkg::CNT_W'(5)));
      push_entry.win       = window_in;
      push_entry.count     = count_ff;
      push_entry.first     = (count_ff == fpds_pkg::CNT_W'(5));
      push_entry.last      = last_eff;
      push_entry.short_seq = (count_ff < fpds_pkg::CNT_W'(5));
   end

   // window and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/fpds_queue.sv]
// fpds_queue: short first-in first-out queue of classified samples
// depends on fpds_pkg

module fpds_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fpds_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output fpds_pkg::entry_type head_entry
);

   fpds_pkg::entry_type store_ff [fpds_pkg::QUEUE_DEPTH];
   logic [fpds_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fpds_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fpds_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == fpds_pkg::QCNT_W'(fpds_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fpds_pkg::QPTR_W'(fpds_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + fpds_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fpds_pkg::QPTR_W'(fpds_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + fpds_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + fpds_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fpds_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/fpds_back.sv]
// fpds_back: walks each queued entry through its results and forms the stencil sums
// depends on fpds_pkg

module fpds_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        mode,
   input  logic                              head_valid,
   input  fpds_pkg::entry_type               head_entry,
   output logic                              pop,
   input  logic                              advance,
   output logic                              sum_valid,
   output logic signed [fpds_pkg::SUM_W-1:0] sum,
   output fpds_pkg::meta_type                sum_meta
);

   fpds_pkg::job_type job_ff, job_in;
   fpds_pkg::job_type cur_job;
   fpds_pkg::job_type next_job;
   logic entry_done;
   logic issue;

   logic [1:0] md;
   logic signed [fpds_pkg::SAMPLE_W-1:0] v [fpds_pkg::WIN_LEN];
   logic signed [fpds_pkg::SUM_W-1:0]    e [fpds_pkg::WIN_LEN];
   logic signed [fpds_pkg::SUM_W-1:0]    far_s, near_s, inner_s, sum_in;
   fpds_pkg::meta_type meta_in;

   logic                              valid_ff;
   logic signed [fpds_pkg::SUM_W-1:0] sum_ff;
   fpds_pkg::meta_type                meta_ff;

   assign issue     = head_valid && advance;
   assign sum_valid = valid_ff;
   assign sum       = sum_ff;
   assign sum_meta  = meta_ff;

   // current result and the one after it
   always_comb begin
      cur_job = job_ff;
      if (job_ff == fpds_pkg::JOB_START) begin
         if (head_entry.short_seq) begin
            cur_job = fpds_pkg::JOB_SHORT;
         end else if (head_entry.first) begin
            cur_job = fpds_pkg::JOB_LEFT_FAR;
         end else begin
            cur_job = fpds_pkg::JOB_INNER_HI;
         end
      end
      entry_done = 1'b0;
      next_job   = fpds_pkg::JOB_START;
      case (cur_job)
         fpds_pkg::JOB_LEFT_FAR:   next_job = fpds_pkg::JOB_LEFT_NEAR;
         fpds_pkg::JOB_LEFT_NEAR:  next_job = fpds_pkg::JOB_INNER_LO;
         fpds_pkg::JOB_INNER_LO:   next_job = fpds_pkg::JOB_INNER_HI;
         fpds_pkg::JOB_INNER_HI: begin
            if (head_entry.last) begin
               next_job = fpds_pkg::JOB_RIGHT_NEAR;
            end else begin
               entry_done = 1'b1;
            end
         end
         fpds_pkg::JOB_RIGHT_NEAR: next_job = fpds_pkg::JOB_RIGHT_FAR;
         default:                  entry_done = 1'b1;
      endcase
   end

   // sequencer outputs
   always_comb begin
      pop    = issue && entry_done;
      job_in = job_ff;
      if (issue) begin
         job_in = entry_done ? fpds_pkg::JOB_START : next_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff   <= fpds_pkg::JOB_START;
         valid_ff <= 1'b0;
      end else if (advance) begin
         job_ff   <= job_in;
         valid_ff <= head_valid;
      end
   end

   // operand order: mirrored for the right end, shifted for the upper interior node
   always_comb begin
      for (int i = 0; i < fpds_pkg::WIN_LEN; i++) begin
         v[i] = $signed(head_entry.win[i]);
      end
      case (cur_job)
         fpds_pkg::JOB_RIGHT_NEAR, fpds_pkg::JOB_RIGHT_FAR: begin
            for (int i = 0; i < fpds_pkg::WIN_LEN; i++) begin
               v[i] = $signed(head_entry.win[fpds_pkg::WIN_LEN-1-i]);
            end
         end
         fpds_pkg::JOB_INNER_HI: begin
            for (int i = 0; i < fpds_pkg::WIN_LEN - 1; i++) begin
               v[i] = $signed(head_entry.win[i+1]);
            end
         end
         default: ;
      endcase
      for (int i = 0; i < fpds_pkg::WIN_LEN; i++) begin
         e[i] = {{(fpds_pkg::SUM_W-fpds_pkg::SAMPLE_W){v[i][fpds_pkg::SAMPLE_W-1]}}, v[i]};
      end
   end

   // stencil sums for the mode in force; mode three behaves as the six-point one
   always_comb begin
      case (mode)
         fpds_pkg::MODE_FIRST:   md = fpds_pkg::MODE_FIRST;
         fpds_pkg::MODE_SECOND5: md = fpds_pkg::MODE_SECOND5;
         default:                md = fpds_pkg::MODE_SECOND6;
      endcase
      case (md)
         fpds_pkg::MODE_FIRST: begin
            far_s   = -e[0]*25 + e[1]*48 - e[2]*36 + e[3]*16 - e[4]*3;
            near_s  = -e[0]*3 - e[1]*10 + e[2]*18 - e[3]*6 + e[4];
            inner_s = e[0] - e[1]*8 + e[3]*8 - e[4];
         end
         fpds_pkg::MODE_SECOND5: begin
            far_s   = e[0]*35 - e[1]*104 + e[2]*114 - e[3]*56 + e[4]*11;
            near_s  = e[0]*11 - e[1]*20 + e[2]*6 + e[3]*4 - e[4];
            inner_s = -e[0] + e[1]*16 - e[2]*30 + e[3]*16 - e[4];
         end
         default: begin
            far_s   = e[0]*45 - e[1]*154 + e[2]*214 - e[3]*156 + e[4]*61 - e[5]*10;
            near_s  = e[0]*10 - e[1]*15 - e[2]*4 + e[3]*14 - e[4]*6 + e[5];
            inner_s = -e[0] + e[1]*16 - e[2]*30 + e[3]*16 - e[4];
         end
      endcase
   end

   // pick the sum and tag the result
   always_comb begin
      meta_in.too_short  = 1'b0;
      meta_in.end_of_run = 1'b0;
      meta_in.node_index = fpds_pkg::NODE_W'(head_entry.count);
      case (cur_job)
         fpds_pkg::JOB_LEFT_FAR: begin
            sum_in             = far_s;
            meta_in.node_index = fpds_pkg::NODE_W'(0);
         end
         fpds_pkg::JOB_LEFT_NEAR: begin
            sum_in             = near_s;
            meta_in.node_index = fpds_pkg::NODE_W'(1);
         end
         fpds_pkg::JOB_INNER_LO: begin
            sum_in             = inner_s;
            meta_in.node_index = fpds_pkg::NODE_W'(2);
         end
         fpds_pkg::JOB_INNER_HI: begin
            sum_in             = inner_s;
            meta_in.node_index = fpds_pkg::NODE_W'(head_entry.count)
                                 - fpds_pkg::NODE_W'(2);
         end
         fpds_pkg::JOB_RIGHT_NEAR: begin
            sum_in             = (md == fpds_pkg::MODE_FIRST) ? -near_s : near_s;
            meta_in.node_index = fpds_pkg::NODE_W'(head_entry.count)
                                 - fpds_pkg::NODE_W'(1);
         end
         fpds_pkg::JOB_RIGHT_FAR: begin
            sum_in             = (md == fpds_pkg::MODE_FIRST) ? -far_s : far_s;
            meta_in.end_of_run = 1'b1;
         end
         default: begin
            sum_in             = '0;
            meta_in.node_index = '0;
            meta_in.too_short  = 1'b1;
            meta_in.end_of_run = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff  <= sum_in;
         meta_ff <= meta_in;
      end
   end

endmodule

[sv/fpds_scale.sv]
// fpds_scale: Q16.16 scaling with round half up and 48-bit saturation, plus output register
// depends on fpds_pkg

module fpds_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fpds_pkg::SCALE_W-1:0]        scale,
   input  logic                                sum_valid,
   input  logic signed [fpds_pkg::SUM_W-1:0]   sum,
   input  fpds_pkg::meta_type                  sum_meta,
   output logic                                advance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fpds_pkg::DERIV_W-1:0] rsp_derivative,
   output logic [fpds_pkg::NODE_W-1:0]         rsp_node_index,
   output logic                                rsp_too_short,
   output logic                                rsp_end_of_run
);

   // magnitude stage
   logic                             a_valid_ff;
   logic                             a_neg_ff;
   logic [fpds_pkg::MAG_W-1:0]       a_mag_ff, a_mag_in;
   fpds_pkg::meta_type               a_meta_ff;
   // partial product stage
   logic                             b_valid_ff;
   logic                             b_neg_ff;
   logic [fpds_pkg::P0_W-1:0]        b_p0_ff, b_p0_in;
   logic [fpds_pkg::P1_W-1:0]        b_p1_ff, b_p1_in;
   fpds_pkg::meta_type               b_meta_ff;
   // product with rounding offset
   logic                             c_valid_ff;
   logic                             c_neg_ff;
   logic [fpds_pkg::FULL_W-1:0]      c_full_ff, c_full_in;
   fpds_pkg::meta_type               c_meta_ff;
   // saturation and sign
   logic [fpds_pkg::QFULL_W-1:0]     q_full;
   logic [fpds_pkg::DERIV_W-1:0]     limit, q_sat, deriv_in;
   logic                             out_valid_ff;
   logic [fpds_pkg::DERIV_W-1:0]     deriv_ff;
   fpds_pkg::meta_type               out_meta_ff;

   // whole pipe moves unless a result is waiting at the output
   assign advance        = !out_valid_ff || rsp_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_derivative = $signed(deriv_ff);
   assign rsp_node_index = out_meta_ff.node_index;
   assign rsp_too_short  = out_meta_ff.too_short;
   assign rsp_end_of_run = out_meta_ff.end_of_run;

   always_comb begin
      a_mag_in = sum[fpds_pkg::SUM_W-1] ? fpds_pkg::MAG_W'(-sum) : fpds_pkg::MAG_W'(sum);
      b_p0_in  = fpds_pkg::P0_W'(a_mag_ff[fpds_pkg::LO_W-1:0]) * fpds_pkg::P0_W'(scale);
      b_p1_in  = fpds_pkg::P1_W'(a_mag_ff[fpds_pkg::MAG_W-1:fpds_pkg::LO_W])
                 * fpds_pkg::P1_W'(scale);
      c_full_in = fpds_pkg::FULL_W'(b_p0_ff)
                  + (fpds_pkg::FULL_W'(b_p1_ff) << fpds_pkg::LO_W)
                  + (b_neg_ff ? fpds_pkg::ROUND_NEG : fpds_pkg::ROUND_POS);
      q_full   = c_full_ff[fpds_pkg::FULL_W-1:fpds_pkg::FRAC_W];
      limit    = c_neg_ff ? fpds_pkg::LIMIT_NEG : fpds_pkg::LIMIT_POS;
      q_sat    = (q_full > fpds_pkg::QFULL_W'(limit)) ? limit
                 : q_full[fpds_pkg::DERIV_W-1:0];
      deriv_in = c_neg_ff ? -q_sat : q_sat;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= sum_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         a_neg_ff    <= sum[fpds_pkg::SUM_W-1];
         a_mag_ff    <= a_mag_in;
         a_meta_ff   <= sum_meta;
         b_neg_ff    <= a_neg_ff;
         b_p0_ff     <= b_p0_in;
         b_p1_ff     <= b_p1_in;
         b_meta_ff   <= a_meta_ff;
         c_neg_ff    <= b_neg_ff;
         c_full_ff   <= c_full_in;
         c_meta_ff   <= b_meta_ff;
         deriv_ff    <= deriv_in;
         out_meta_ff <= c_meta_ff;
      end
   end

endmodule

[sv/five_point_derivative_stencil_core.sv]
// five_point_derivative_stencil_core: top level of the five-point derivative stencil
// depends on fpds_pkg, fpds_front, fpds_queue, fpds_back, fpds_scale
//
// Usage
//   req_*  : one sample per transaction; req_last flags the final sample of a sequence.
//   rsp_*  : one derivative per node, in node order; rsp_end_of_run on the final one.
//            A sequence under six samples gives a single transaction with
//            rsp_too_short set and a zero derivative.
//   csr_*  : index 0 mode, index 1 Q16.16 scale; always ready, write only while idle.
// Throughput : while rsp_ready is high, one sample per cycle sustained, one result per
//            cycle out. Samples that close a sequence (up to six results from one
//            sample) wait in an 8-entry queue between the sample window and the
//            stencil sequencer, which turns out one result per cycle while not held.
// Path       : a sample transaction passes the queue, the sequencer stage and the
//            four-stage scaling pipeline before its first result is valid.
// Reset      : mode 0, scale 1.0, sequence count cleared, queue and pipeline empty.
// Stall      : a result waiting on rsp_ready holds the sequencer and scaling pipeline;
//            samples still go into the queue until it is full, then req_ready drops.

module five_point_derivative_stencil_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fpds_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fpds_pkg::DERIV_W-1:0]   rsp_derivative,
   output logic [fpds_pkg::NODE_W-1:0]           rsp_node_index,
   output logic                                  rsp_too_short,
   output logic                                  rsp_end_of_run,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fpds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [31:0]                           csr_wdata
);

   logic [1:0]                        mode_ff;
   logic [fpds_pkg::SCALE_W-1:0]      scale_ff;
   logic                              push;
   fpds_pkg::entry_type               push_entry;
   logic                              queue_full;
   logic                              pop;
   logic                              head_valid;
   fpds_pkg::entry_type               head_entry;
   logic                              advance;
   logic                              sum_valid;
   logic signed [fpds_pkg::SUM_W-1:0] sum;
   fpds_pkg::meta_type                sum_meta;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= fpds_pkg::MODE_FIRST;
         scale_ff <= fpds_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fpds_pkg::CSR_MODE:  mode_ff  <= csr_wdata[1:0];
            fpds_pkg::CSR_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample window and classification
   fpds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // queue between front and back
   fpds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // result sequencer and stencil sums
   fpds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .advance    (advance),
      .sum_valid  (sum_valid),
      .sum        (sum),
      .sum_meta   (sum_meta)
   );

   // scaling, rounding, saturation and output register
   fpds_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .scale          (scale_ff),
      .sum_valid      (sum_valid),
      .sum            (sum),
      .sum_meta       (sum_meta),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_derivative (rsp_derivative),
      .rsp_node_index (rsp_node_index),
      .rsp_too_short  (rsp_too_short),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

[dv/five_point_derivative_stencil_core_tb.sv]
// five_point_derivative_stencil_core_tb: self-checking testbench for the derivative stencil core
// holds a scoreboard class that predicts every node result; depends on fpds_pkg and the core

module five_point_derivative_stencil_core_tb;
   import fpds_pkg::*;

   localparam int LIMIT_TIME     = 15_000_000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int ITEMS_PER_PASS = 30;
   localparam int NUM_PASSES     = 8;
   localparam int IDLE_PERCENT   = 20;

   // mode code outside the documented range, behaves as the six-point mode
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;

   typedef struct {
      logic [DERIV_W-1:0] derivative;
      logic [NODE_W-1:0]  node_index;
      logic               too_short;
      logic               end_of_run;
   } node_result_t;

   // predicts the node results of the sample stream and checks them in order
   class derivative_scoreboard;
      logic [1:0]     mode_reg;
      logic [31:0]    scale_reg;
      longint         win[WIN_LEN];
      int unsigned    count;
      node_result_t   expected_nodes[$];
      int             failures;

      function new();
         mode_reg  = MODE_FIRST;
         scale_reg = SCALE_RESET;
         foreach (win[i]) win[i] = 0;
         count    = 0;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         if (idx == CSR_MODE)
            mode_reg = val[1:0];
         else
            scale_reg = val;
      endfunction

      function int pending();
         return expected_nodes.size();
      endfunction

      // one-sided stencils, v[0] is the end sample
      function longint end_stencil(longint v[WIN_LEN], bit near_node, logic [1:0] md);
         if (md == MODE_FIRST) begin
            if (!near_node)
               return -25 * v[0] + 48 * v[1] - 36 * v[2] + 16 * v[3] - 3 * v[4];
            return -3 * v[0] - 10 * v[1] + 18 * v[2] - 6 * v[3] + v[4];
         end
         if (md == MODE_SECOND5) begin
            if (!near_node)
               return 35 * v[0] - 104 * v[1] + 114 * v[2] - 56 * v[3] + 11 * v[4];
            return 11 * v[0] - 20 * v[1] + 6 * v[2] + 4 * v[3] - v[4];
         end
         if (!near_node)
            return 45 * v[0] - 154 * v[1] + 214 * v[2] - 156 * v[3] + 61 * v[4]
                   - 10 * v[5];
         return 10 * v[0] - 15 * v[1] - 4 * v[2] + 14 * v[3] - 6 * v[4] + v[5];
      endfunction

      // centred stencil over win[base .. base+4]
      function longint inner_stencil(int base, logic [1:0] md);
         if (md == MODE_FIRST)
            return win[base] - 8 * win[base+1] + 8 * win[base+3] - win[base+4];
         return -win[base] + 16 * win[base+1] - 30 * win[base+2] + 16 * win[base+3]
                - win[base+4];
      endfunction

      // q16.16 scaling, half up on the signed value, saturated to 48 bits
      function logic [DERIV_W-1:0] scaled(longint s);
         logic        neg;
         logic [65:0] mag;
         logic [65:0] prod;
         logic [65:0] q;
         logic [65:0] lim;
         neg  = (s < 0);
         mag  = neg ? 66'(-s) : 66'(s);
         prod = mag * 66'(scale_reg) + (neg ? 66'd32767 : 66'd32768);
         q    = prod >> FRAC_W;
         lim  = neg ? (66'd1 << (DERIV_W - 1)) : ((66'd1 << (DERIV_W - 1)) - 66'd1);
         if (q > lim)
            q = lim;
         return neg ? DERIV_W'(-q) : DERIV_W'(q);
      endfunction

      function void push_node(logic [DERIV_W-1:0] d, int unsigned node, bit ts, bit eor);
         node_result_t r;
         r.derivative = d;
         r.node_index = NODE_W'(node);
         r.too_short  = ts;
         r.end_of_run = eor;
         expected_nodes.push_back(r);
      endfunction

      // accepted sample: advance the window and queue the nodes it completes
      function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic lst);
         logic [1:0]  md;
         int unsigned k;
         bit          at_end;
         longint      rev[WIN_LEN];
         longint      s;
         md     = (mode_reg == MODE_SPARE) ? MODE_SECOND6 : mode_reg;
         k      = count;
         at_end = lst || (k >= MAX_LENGTH - 1);
         for (int i = 0; i < WIN_LEN - 1; i++)
            win[i] = win[i+1];
         win[WIN_LEN-1] = longint'(smp);

         // fewer than six samples so far
         if (k < 5) begin
            if (at_end) begin
               push_node('0, 0, 1'b1, 1'b1);
               count = 0;
            end else begin
               count = k + 1;
            end
            return;
         end

         // window first full: left end nodes and node two
         if (k == 5) begin
            push_node(scaled(end_stencil(win, 1'b0, md)), 0, 1'b0, 1'b0);
            push_node(scaled(end_stencil(win, 1'b1, md)), 1, 1'b0, 1'b0);
            push_node(scaled(inner_stencil(0, md)), 2, 1'b0, 1'b0);
         end
         push_node(scaled(inner_stencil(1, md)), k - 2, 1'b0, 1'b0);

         // right end, mirrored window, sign flipped for the first derivative
         if (at_end) begin
            for (int j = 0; j < WIN_LEN; j++)
               rev[j] = win[WIN_LEN-1-j];
            s = end_stencil(rev, 1'b1, md);
            if (md == MODE_FIRST)
               s = -s;
            push_node(scaled(s), k - 1, 1'b0, 1'b0);
            s = end_stencil(rev, 1'b0, md);
            if (md == MODE_FIRST)
               s = -s;
            push_node(scaled(s), k, 1'b0, 1'b1);
            count = 0;
         end else begin
            count = k + 1;
         end
      endfunction

      function void check_node(logic [DERIV_W-1:0] d, logic [NODE_W-1:0] node,
                               logic ts, logic eor);
         node_result_t want;
         if (expected_nodes.size() == 0) begin
            $display("%0t: unexpected result node %0d derivative %0d too_short %0b end %0b",
                     $time, node, $signed(d), ts, eor);
            failures++;
            return;
         end
         want = expected_nodes.pop_front();
         if (d !== want.derivative) begin
            $display("%0t: derivative mismatch at node %0d expected %0d actual %0d",
                     $time, want.node_index, $signed(want.derivative), $signed(d));
            failures++;
         end
         if (node !== want.node_index) begin
            $display("%0t: node_index mismatch expected %0d actual %0d",
                     $time, want.node_index, node);
            failures++;
         end
         if (ts !== want.too_short) begin
            $display("%0t: too_short mismatch at node %0d expected %0b actual %0b",
                     $time, want.node_index, want.too_short, ts);
            failures++;
         end
         if (eor !== want.end_of_run) begin
            $display("%0t: end_of_run mismatch at node %0d expected %0b actual %0b",
                     $time, want.node_index, want.end_of_run, eor);
            failures++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample;
   logic                         req_last;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [DERIV_W-1:0]    rsp_derivative;
   logic [NODE_W-1:0]            rsp_node_index;
   logic                         rsp_too_short;
   logic                         rsp_end_of_run;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [31:0]                  csr_wdata;

   derivative_scoreboard sb;
   bit no_idle;
   bit hold_request;

   five_point_derivative_stencil_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_derivative (rsp_derivative),
      .rsp_node_index (rsp_node_index),
      .rsp_too_short  (rsp_too_short),
      .rsp_end_of_run (rsp_end_of_run),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random back-pressure, long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // result transactions go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_node(rsp_derivative, rsp_node_index, rsp_too_short, rsp_end_of_run);
   end

   // one sample transaction, with random gaps ahead of it
   task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic lst);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      req_last   <= lst;
      @(posedge clock);
      while (req_ready !== 1'b1)
         @(posedge clock);
      sb.note_sample(smp, lst);
      @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style);
      logic signed [SAMPLE_W-1:0] v;
      case (style)
         0: v = SAMPLE_W'($urandom());
         1: begin
            case ($urandom_range(4))
               0:       v = SAMPLE_MAX;
               1:       v = SAMPLE_MIN;
               2:       v = '0;
               3:       v = '1;
               default: v = 24'sd1;
            endcase
         end
         default: v = SAMPLE_W'($urandom_range(200)) - 24'sd100;
      endcase
      return v;
   endfunction

   task automatic send_run(int len, int style);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(style), i == len - 1);
   endtask

   // alternating extremes drive the stencil sums to their largest magnitude
   task automatic send_alternating(int len);
      for (int i = 0; i < len; i++)
         send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == len - 1);
   endtask

   task automatic send_random_runs(int budget);
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(99);
         if (r < 10)
            len = $urandom_range(5, 1);
         else if (r < 80)
            len = $urandom_range(16, 6);
         else
            len = $urandom_range(48, 17);
         send_run(len, $urandom_range(2));
         sent += len;
      end
   endtask

   // stop offering and let every expected result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // both register writes back to back, valid held across them
   task automatic configure(logic [1:0] md, logic [31:0] scl);
      logic [31:0] mode_word;
      mode_word = {($urandom_range(1) == 1) ? 30'($urandom()) : 30'd0, md};
      csr_valid <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      sb.write_reg(CSR_MODE, mode_word);
      @(negedge clock);
      csr_index <= CSR_SCALE;
      csr_wdata <= scl;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      sb.write_reg(CSR_SCALE, scl);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin : stimulus
      logic [1:0]  md;
      logic [31:0] scl;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      req_last     = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_MODE;
      csr_wdata    = '0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      sb = new();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, single-sample and five-sample runs, extremes
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample('0, 1'b0);
      send_sample(24'sd1, 1'b0);
      send_sample('1, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      send_alternating(6);
      send_run(7, 1);
      wait_idle();

      // passes over every mode, scale extremes and random scales
      for (int p = 0; p < NUM_PASSES; p++) begin
         case (p)
            0:       begin md = MODE_SECOND5; scl = SCALE_RESET;             end
            1:       begin md = MODE_SECOND6; scl = 32'hFFFF_FFFF;           end
            2:       begin md = MODE_SPARE;   scl = $urandom();              end
            3:       begin md = MODE_FIRST;   scl = '0;                      end
            4:       begin md = MODE_SECOND5; scl = 32'hFFFF_FFFF;           end
            5:       begin md = MODE_SECOND6; scl = $urandom_range(4096, 1); end
            6:       begin md = MODE_FIRST;   scl = 32'hFFFF_FFFF;           end
            default: begin md = MODE_SPARE;   scl = 32'hFFFF_FFFF;           end
         endcase
         configure(md, scl);
         no_idle = (p == 0);
         if (p == 2)
            hold_request = 1'b1;
         send_alternating(6);
         send_alternating(7);
         if (p == 4) begin
            // sender waits for the block to empty midway
            send_random_runs(ITEMS_PER_PASS / 2);
            req_valid <= 1'b0;
            while (sb.pending() != 0)
               @(posedge clock);
            @(negedge clock);
            send_random_runs(ITEMS_PER_PASS / 2);
         end else begin
            send_random_runs(ITEMS_PER_PASS);
         end
         no_idle = 1'b0;
         wait_idle();
      end

      if (sb.failures == 0 && sb.pending() == 0)
         $display("five_point_derivative_stencil_core verification clean");
      else
         $display("five_point_derivative_stencil_core verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_TIME);
      $display("five_point_derivative_stencil_core verification failed");
      $finish;
   end

endmodule
